// ----- rtl/sei_pkg.sv -----
// ----------------------------------------------------------------------------
// sei_pkg
// Shared widths, sine coefficients and helpers for the ease interpolator.
// ----------------------------------------------------------------------------
package sei_pkg;

    localparam int SEI_TIME_BITS  = 16;
    localparam int SEI_VALUE_BITS = 16;
    localparam int SEI_PHASE_BITS = 16;

    // Q1.30 quarter-wave argument and Q1.30 coefficients
    localparam int Q30_FRAC = 30;
    localparam int Q30_BITS = 31;
    localparam int MUL_BITS = 2 * Q30_BITS;
    localparam int ACC_BITS = 34;

    localparam logic [Q30_BITS-1:0] SIN_C1 = 31'd1686629713;
    localparam logic [Q30_BITS-1:0] SIN_C3 = 31'd693598668;
    localparam logic [Q30_BITS-1:0] SIN_C5 = 31'd85569306;
    localparam logic [Q30_BITS-1:0] SIN_C7 = 31'd5026995;
    localparam logic [Q30_BITS-1:0] SIN_C9 = 31'd172272;

    // Q1.15 sine output
    localparam int                  SINE_BITS   = 16;
    localparam int                  SINE_SHIFT  = 15;
    localparam logic [ACC_BITS-1:0] SINE_ROUND  = 34'd16384;
    localparam logic [SINE_BITS-1:0] SINE_ONE   = 16'd32768;
    localparam int                  SINE_STAGES = 9;

    // Q1.16 ease factor and blend rounding
    localparam int                 EASE_BITS  = 17;
    localparam logic [EASE_BITS-1:0] EASE_HALF = 17'd32768;
    localparam int                 BLEND_FRAC = 16;
    localparam int                 BLEND_ROUND = 32768;

    // Queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

    // Q1.30 by Q1.30 (or Q1.30 coefficient) product, truncated to Q1.30
    function automatic logic [Q30_BITS-1:0] mul_q30(input logic [Q30_BITS-1:0] a,
                                                    input logic [Q30_BITS-1:0] b);
        logic [MUL_BITS-1:0] p;
        p = {{Q30_BITS{1'b0}}, a} * {{Q30_BITS{1'b0}}, b};
        return p[Q30_FRAC+Q30_BITS-1:Q30_FRAC];
    endfunction

endpackage

// ----- rtl/sei_in_if.sv -----
// ----------------------------------------------------------------------------
// sei_in_if
// Input channel: timing and endpoint values of one move sample.
// ----------------------------------------------------------------------------
interface sei_in_if
    import sei_pkg::*;
#(
    parameter int TIME_BITS  = SEI_TIME_BITS,
    parameter int VALUE_BITS = SEI_VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic        [TIME_BITS-1:0]  elapsed_time;
    logic        [TIME_BITS-1:0]  total_time;
    logic signed [VALUE_BITS-1:0] start_value;
    logic signed [VALUE_BITS-1:0] end_value;

    modport source (
        output valid, elapsed_time, total_time, start_value, end_value,
        input  ready
    );

    modport sink (
        input  valid, elapsed_time, total_time, start_value, end_value,
        output ready
    );
endinterface

// ----- rtl/sei_out_if.sv -----
// ----------------------------------------------------------------------------
// sei_out_if
// Output channel: eased value and zero-duration flag.
// ----------------------------------------------------------------------------
interface sei_out_if
    import sei_pkg::*;
#(
    parameter int VALUE_BITS = SEI_VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] interpolated_value;
    logic                         zero_duration;

    modport source (
        output valid, interpolated_value, zero_duration,
        input  ready
    );

    modport sink (
        input  valid, interpolated_value, zero_duration,
        output ready
    );
endinterface

// ----- rtl/sine_ease_interpolator_unit.sv -----
// ----------------------------------------------------------------------------
// sine_ease_interpolator_unit
// Eased interpolation start + f(r)*(end - start), f(r) = (1 + sin((r-1/2)pi))/2.
//
// i_in carries elapsed time, total time, start and end value; o_out returns
// the rounded eased value and a zero-duration flag, one result per
// transaction, in order. Elapsed beyond total saturates; a zero total returns
// the end value with the flag set.
// Throughput: one transaction per cycle while o_out is taken.
// Path from acceptance to o_out.valid: the queue entry register, PHASE_BITS + 1
// divider stages, nine sine stages, three blend stages with the output
// register last (the queue is not read straight through when empty); the
// divider's one-bit-per-stage chain is the longest part of the path.
// Reset empties the four-entry queue and clears all stage valids.
// When the receiver stalls, the back pipeline holds; the front keeps
// accepting until the queue is full, then drops i_in.ready.
// ----------------------------------------------------------------------------
module sine_ease_interpolator_unit
    import sei_pkg::*;
#(
    parameter int TIME_BITS  = SEI_TIME_BITS,
    parameter int VALUE_BITS = SEI_VALUE_BITS,
    parameter int PHASE_BITS = SEI_PHASE_BITS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sei_in_if.sink    i_in,
    sei_out_if.source o_out
);

    localparam int ITEM_BITS = 2 * TIME_BITS + 2 * VALUE_BITS + 1;

    logic                 q_valid;
    logic [ITEM_BITS-1:0] q_data;
    logic                 pop;

    sei_front #(
        .TIME_BITS  (TIME_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_pop     (pop)
    );

    sei_back #(
        .TIME_BITS  (TIME_BITS),
        .VALUE_BITS (VALUE_BITS),
        .PHASE_BITS (PHASE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

// ----- rtl/sei_front.sv -----
// ----------------------------------------------------------------------------
// sei_front
// Accept transactions, saturate elapsed time, flag zero duration, and queue
// the classified item for the back end.
// ----------------------------------------------------------------------------
module sei_front
    import sei_pkg::*;
#(
    parameter int TIME_BITS  = SEI_TIME_BITS,
    parameter int VALUE_BITS = SEI_VALUE_BITS,
    localparam int ITEM_BITS = 2 * TIME_BITS + 2 * VALUE_BITS + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    sei_in_if.sink               i_in,
    output logic                 o_q_valid,
    output logic [ITEM_BITS-1:0] o_q_data,
    input  logic                 i_pop
);

    logic [ITEM_BITS-1:0]      r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;
    logic [QUEUE_PTR_BITS-1:0] n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] n_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] n_count;
    logic                      push;
    logic                      zero;
    logic [TIME_BITS-1:0]      sat_elapsed;

    assign i_in.ready  = (r_count != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign push        = i_in.valid && i_in.ready;
    assign zero        = (i_in.total_time == '0);
    assign sat_elapsed = (i_in.elapsed_time > i_in.total_time) ? i_in.total_time
                                                               : i_in.elapsed_time;

    assign o_q_valid = (r_count != '0);
    assign o_q_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push  ? r_wr_ptr + QUEUE_PTR_BITS'(1) : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + QUEUE_PTR_BITS'(1) : r_rd_ptr;
        case ({push, i_pop})
            2'b10:   n_count = r_count + QUEUE_CNT_BITS'(1);
            2'b01:   n_count = r_count - QUEUE_CNT_BITS'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= {zero, i_in.end_value, i_in.start_value,
                                i_in.total_time, sat_elapsed};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !i_pop |=> r_count == QUEUE_CNT_BITS'($past(r_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

// ----- rtl/sei_div.sv -----
// ----------------------------------------------------------------------------
// sei_div
// Pipelined restoring divider: ratio = (num << PHASE_BITS) / den, num <= den,
// one quotient bit per stage.
// ----------------------------------------------------------------------------
module sei_div
    import sei_pkg::*;
#(
    parameter int TIME_BITS  = SEI_TIME_BITS,
    parameter int PHASE_BITS = SEI_PHASE_BITS,
    parameter int SB_BITS    = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_pipe_ctl             i_ctl,
    input  logic [TIME_BITS-1:0]  i_num,
    input  logic [TIME_BITS-1:0]  i_den,
    input  logic [SB_BITS-1:0]    i_sb,
    output logic                  o_valid,
    output logic [PHASE_BITS:0]   o_quot,
    output logic [SB_BITS-1:0]    o_sb
);

    localparam int STAGES = PHASE_BITS + 1;

    logic                 r_vld [STAGES];
    logic [TIME_BITS-1:0] r_rem [STAGES];
    logic [TIME_BITS-1:0] r_den [STAGES];
    logic [PHASE_BITS:0]  r_q   [STAGES];
    logic [SB_BITS-1:0]   r_sb  [STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic                 vld_in;
        logic [TIME_BITS:0]   trial;
        logic [TIME_BITS-1:0] den_in;
        logic [PHASE_BITS:0]  q_in;
        logic [SB_BITS-1:0]   sb_in;
        logic [TIME_BITS:0]   diff;
        logic                 ge;

        if (k == 0) begin : g_first
            assign vld_in = i_ctl.valid;
            assign trial  = {1'b0, i_num};
            assign den_in = i_den;
            assign q_in   = '0;
            assign sb_in  = i_sb;
        end else begin : g_next
            assign vld_in = r_vld[k-1];
            assign trial  = {r_rem[k-1], 1'b0};
            assign den_in = r_den[k-1];
            assign q_in   = r_q[k-1];
            assign sb_in  = r_sb[k-1];
        end

        assign ge   = (trial >= {1'b0, den_in});
        assign diff = trial - {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_ctl.en) begin
                r_vld[k] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem[k] <= ge ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
                r_den[k] <= den_in;
                r_q[k]   <= {q_in[PHASE_BITS-1:0], ge};
                r_sb[k]  <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_quot  = r_q[STAGES-1];
    assign o_sb    = r_sb[STAGES-1];

endmodule

// ----- rtl/sei_sine.sv -----
// ----------------------------------------------------------------------------
// sei_sine
// Quarter-wave sine of |2r - 1| by an odd ninth-order polynomial, one
// multiply per operand path per stage, result rounded to Q1.15.
// ----------------------------------------------------------------------------
module sei_sine
    import sei_pkg::*;
#(
    parameter int PHASE_BITS = SEI_PHASE_BITS,
    parameter int SB_BITS    = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_pipe_ctl            i_ctl,
    input  logic [PHASE_BITS:0]  i_ratio,
    input  logic [SB_BITS-1:0]   i_sb,
    output logic                 o_valid,
    output logic                 o_pos,
    output logic [SINE_BITS-1:0] o_sine,
    output logic [SB_BITS-1:0]   o_sb
);

    localparam logic [PHASE_BITS:0] HALF = (PHASE_BITS + 1)'(1) << (PHASE_BITS - 1);

    logic                       r_vld [SINE_STAGES];
    logic                       r_pos [SINE_STAGES];
    logic [SB_BITS-1:0]         r_sb  [SINE_STAGES];

    logic [Q30_BITS-1:0]        r_x;
    logic [Q30_BITS-1:0]        r_x_1;
    logic [Q30_BITS-1:0]        r_x2_1, r_x2_2, r_x2_3, r_x2_4;
    logic [Q30_BITS-1:0]        r_t1_1, r_t1_2, r_t1_3;
    logic [Q30_BITS-1:0]        r_x3_2;
    logic [Q30_BITS-1:0]        r_t3_3;
    logic [Q30_BITS-1:0]        r_x5_3, r_x7_4, r_x9_5;
    logic [Q30_BITS-1:0]        r_t5_4, r_t7_5, r_t9_6;
    logic signed [ACC_BITS-1:0] r_acc_4, r_acc_5, r_acc_6, r_acc_7;
    logic [SINE_BITS-1:0]       r_sine;

    logic                       pos;
    logic [PHASE_BITS:0]        phase_off;
    logic [ACC_BITS-1:0]        rounded;
    logic [ACC_BITS-1:0]        n_q;
    logic [SINE_BITS-1:0]       n_sine;

    assign pos       = (i_ratio >= HALF);
    assign phase_off = pos ? (i_ratio - HALF) : (HALF - i_ratio);

    always_comb begin
        rounded = ACC_BITS'(r_acc_7) + SINE_ROUND;
        n_q     = rounded >> SINE_SHIFT;
        if (r_acc_7 <= 0) begin
            n_sine = '0;
        end else if (n_q > ACC_BITS'(SINE_ONE)) begin
            n_sine = SINE_ONE;
        end else begin
            n_sine = n_q[SINE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SINE_STAGES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (i_ctl.en) begin
            r_vld[0] <= i_ctl.valid;
            for (int k = 1; k < SINE_STAGES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_pos[0] <= pos;
            r_sb[0]  <= i_sb;
            for (int k = 1; k < SINE_STAGES; k++) begin
                r_pos[k] <= r_pos[k-1];
                r_sb[k]  <= r_sb[k-1];
            end

            r_x     <= {phase_off[PHASE_BITS-1:0], 1'b0, {(Q30_FRAC - PHASE_BITS){1'b0}}};

            r_x_1   <= r_x;
            r_x2_1  <= mul_q30(r_x, r_x);
            r_t1_1  <= mul_q30(SIN_C1, r_x);

            r_x3_2  <= mul_q30(r_x2_1, r_x_1);
            r_x2_2  <= r_x2_1;
            r_t1_2  <= r_t1_1;

            r_x5_3  <= mul_q30(r_x3_2, r_x2_2);
            r_t3_3  <= mul_q30(SIN_C3, r_x3_2);
            r_x2_3  <= r_x2_2;
            r_t1_3  <= r_t1_2;

            r_x7_4  <= mul_q30(r_x5_3, r_x2_3);
            r_t5_4  <= mul_q30(SIN_C5, r_x5_3);
            r_acc_4 <= $signed({3'b0, r_t1_3}) - $signed({3'b0, r_t3_3});
            r_x2_4  <= r_x2_3;

            r_x9_5  <= mul_q30(r_x7_4, r_x2_4);
            r_t7_5  <= mul_q30(SIN_C7, r_x7_4);
            r_acc_5 <= r_acc_4 + $signed({3'b0, r_t5_4});

            r_t9_6  <= mul_q30(SIN_C9, r_x9_5);
            r_acc_6 <= r_acc_5 - $signed({3'b0, r_t7_5});

            r_acc_7 <= r_acc_6 + $signed({3'b0, r_t9_6});

            r_sine  <= n_sine;
        end
    end

    assign o_valid = r_vld[SINE_STAGES-1];
    assign o_pos   = r_pos[SINE_STAGES-1];
    assign o_sine  = r_sine;
    assign o_sb    = r_sb[SINE_STAGES-1];

endmodule

// ----- rtl/sei_back.sv -----
// ----------------------------------------------------------------------------
// sei_back
// Pop queued items, divide, ease through the sine pipeline, blend between start
// and end (end alone for zero duration), and hold the result in the output register.
// ----------------------------------------------------------------------------
module sei_back
    import sei_pkg::*;
#(
    parameter int TIME_BITS  = SEI_TIME_BITS,
    parameter int VALUE_BITS = SEI_VALUE_BITS,
    parameter int PHASE_BITS = SEI_PHASE_BITS,
    localparam int ITEM_BITS = 2 * TIME_BITS + 2 * VALUE_BITS + 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  logic [ITEM_BITS-1:0] i_q_data,
    output logic                 o_pop,
    sei_out_if.source            o_out
);

    localparam int SB_BITS   = 2 * VALUE_BITS + 1;
    localparam int DIFF_BITS = VALUE_BITS + 1;
    localparam int PROD_BITS = VALUE_BITS + EASE_BITS + 2;

    logic                        en;
    t_pipe_ctl                   div_ctl;
    t_pipe_ctl                   sine_ctl;
    logic [TIME_BITS-1:0]        q_elapsed;
    logic [TIME_BITS-1:0]        q_total;
    logic [SB_BITS-1:0]          q_sb;
    logic                        div_vld;
    logic [PHASE_BITS:0]         div_q;
    logic [SB_BITS-1:0]          div_sb;
    logic                        sin_vld;
    logic                        sin_pos;
    logic [SINE_BITS-1:0]        sin_q;
    logic [SB_BITS-1:0]          sin_sb;
    logic signed [VALUE_BITS-1:0] sin_start;
    logic signed [VALUE_BITS-1:0] sin_end;

    logic                         r_b0_vld;
    logic [EASE_BITS-1:0]         r_f;
    logic signed [DIFF_BITS-1:0]  r_diff;
    logic signed [VALUE_BITS-1:0] r_b0_start;
    logic signed [VALUE_BITS-1:0] r_b0_end;
    logic                         r_b0_zero;

    logic                         r_b1_vld;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [VALUE_BITS-1:0] r_b1_start;
    logic signed [VALUE_BITS-1:0] r_b1_end;
    logic                         r_b1_zero;

    logic                         r_out_vld;
    logic signed [VALUE_BITS-1:0] r_out_value;
    logic                         r_out_zero;

    logic [EASE_BITS-1:0]         n_f;
    logic signed [DIFF_BITS-1:0]  n_diff;
    logic signed [PROD_BITS-1:0]  rnd;
    logic [VALUE_BITS-1:0]        n_value;

    assign en    = !r_out_vld || o_out.ready;
    assign o_pop = en && i_q_valid;

    assign q_elapsed = i_q_data[TIME_BITS-1:0];
    assign q_total   = i_q_data[2*TIME_BITS-1:TIME_BITS];
    assign q_sb      = i_q_data[ITEM_BITS-1:2*TIME_BITS];

    assign div_ctl  = '{en: en, valid: i_q_valid};
    assign sine_ctl = '{en: en, valid: div_vld};

    sei_div #(
        .TIME_BITS  (TIME_BITS),
        .PHASE_BITS (PHASE_BITS),
        .SB_BITS    (SB_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (q_elapsed),
        .i_den   (q_total),
        .i_sb    (q_sb),
        .o_valid (div_vld),
        .o_quot  (div_q),
        .o_sb    (div_sb)
    );

    sei_sine #(
        .PHASE_BITS (PHASE_BITS),
        .SB_BITS    (SB_BITS)
    ) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sine_ctl),
        .i_ratio (div_q),
        .i_sb    (div_sb),
        .o_valid (sin_vld),
        .o_pos   (sin_pos),
        .o_sine  (sin_q),
        .o_sb    (sin_sb)
    );

    assign sin_start = sin_sb[VALUE_BITS-1:0];
    assign sin_end   = sin_sb[2*VALUE_BITS-1:VALUE_BITS];

    always_comb begin
        n_f     = sin_pos ? (EASE_HALF + EASE_BITS'(sin_q)) : (EASE_HALF - EASE_BITS'(sin_q));
        n_diff  = {sin_end[VALUE_BITS-1], sin_end} - {sin_start[VALUE_BITS-1], sin_start};
        rnd     = r_prod + PROD_BITS'(BLEND_ROUND);
        n_value = r_b1_start + rnd[BLEND_FRAC+VALUE_BITS-1:BLEND_FRAC];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_vld  <= 1'b0;
            r_b1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_b0_vld  <= sin_vld;
            r_b1_vld  <= r_b0_vld;
            r_out_vld <= r_b1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f         <= n_f;
            r_diff      <= n_diff;
            r_b0_start  <= sin_start;
            r_b0_end    <= sin_end;
            r_b0_zero   <= sin_sb[SB_BITS-1];

            r_prod      <= $signed({1'b0, r_f}) * r_diff;
            r_b1_start  <= r_b0_start;
            r_b1_end    <= r_b0_end;
            r_b1_zero   <= r_b0_zero;

            r_out_value <= r_b1_zero ? r_b1_end : $signed(n_value);
            r_out_zero  <= r_b1_zero;
        end
    end

    assign o_out.valid              = r_out_vld;
    assign o_out.interpolated_value = r_out_value;
    assign o_out.zero_duration      = r_out_zero;

    a_stall_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !o_out.ready |-> !o_pop)
        else $error("queue popped while output stalled");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sin_vld |-> sin_q <= SINE_ONE)
        else $error("sine above one");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(div_q) && $stable(sin_q) && $stable(r_prod))
        else $error("pipeline moved while stalled");

endmodule
